// File: design/packed_sprite_palette_blitter_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sprite blitter
// Shared concurrent check forms; clocked on clk, disabled during rst.
// ---------------------------------------------------------------------------
`ifndef PACKED_SPRITE_PALETTE_BLITTER_UNIT_MACROS_SVH
`define PACKED_SPRITE_PALETTE_BLITTER_UNIT_MACROS_SVH

// same-cycle implication
`define PSPB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pspb: same-cycle check failed");

// next-cycle implication
`define PSPB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pspb: next-cycle check failed");

`endif

// File: design/pspb_pkg.sv
// ---------------------------------------------------------------------------
// pspb_pkg
// Types, constants and pixel unpacking shared by the blitter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package pspb_pkg;

  localparam int ADDR_BITS   = 24;
  localparam int MAX_WIDTH   = 1024;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_1BPP = 2'd0,
    MODE_2BPP = 2'd1,
    MODE_4BPP = 2'd2,
    MODE_8BPP = 2'd3
  } pix_mode_t;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_WIDTH     = 3'd1,
    REG_ROW_BYTES = 3'd2,
    REG_START     = 3'd3,
    REG_PITCH     = 3'd4,
    REG_KEY       = 3'd5,
    REG_PAL_LO    = 3'd6,
    REG_PAL_HI    = 3'd7
  } reg_idx_t;

  // live configuration (the user changes it only while idle; not enforced here)
  typedef struct packed {
    pix_mode_t              mode;
    logic [10:0]            width;
    logic [10:0]            row_bytes;
    logic [ADDR_BITS-1:0]   dest_start;
    logic [12:0]            pitch;
    logic [8:0]             key;      // bit 8 set: opaque
    logic [127:0]           palette;  // entry 0 in bits 7:0
  } cfg_t;

  // one source word with at least one pixel to write
  typedef struct packed {
    logic [7:0]           src_byte;
    logic [7:0]           mask;       // slot s is written
    logic [ADDR_BITS-1:0] base;       // address of slot 0
  } entry_t;

  function automatic logic [3:0] slot_count(pix_mode_t mode);
    logic [3:0] n;
    unique case (mode)
      MODE_1BPP: n = 4'd8;
      MODE_2BPP: n = 4'd4;
      MODE_4BPP: n = 4'd2;
      MODE_8BPP: n = 4'd1;
      default:   n = 4'd1;
    endcase
    return n;
  endfunction

  // MSB-first index of slot s; undefined slots give don't-care values
  function automatic logic [7:0] slot_index(logic [7:0] b, pix_mode_t mode, logic [2:0] s);
    logic [7:0] idx;
    unique case (mode)
      MODE_1BPP: idx = (b >> (3'd7 - s)) & 8'h01;
      MODE_2BPP: idx = (b >> (3'd6 - {s[1:0], 1'b0})) & 8'h03;
      MODE_4BPP: idx = (b >> (3'd4 - {s[0], 2'b00})) & 8'h0F;
      MODE_8BPP: idx = b;
      default:   idx = b;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: design/pspb_if.sv
// ---------------------------------------------------------------------------
// pspb_if
// Valid/ready channels: source words in, framebuffer write words out.
// ---------------------------------------------------------------------------
`default_nettype none

interface pspb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       last_of_sprite;

  modport source (output valid, source_byte, last_of_sprite, input ready);
  modport sink   (input valid, source_byte, last_of_sprite, output ready);
endinterface

interface pspb_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] write_address;
  logic [7:0]  pixel_color;
  logic        last_in_run;

  modport source (output valid, write_address, pixel_color, last_in_run, input ready);
  modport sink   (input valid, write_address, pixel_color, last_in_run, output ready);
endinterface

`default_nettype wire

// File: design/pspb_front.sv
// ---------------------------------------------------------------------------
// pspb_front
// Takes source words, tracks row/column position, builds write masks.
// ---------------------------------------------------------------------------
`default_nettype none
`include "packed_sprite_palette_blitter_unit_macros.svh"

module pspb_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire pspb_pkg::cfg_t                   cfg,
  input  wire logic                             restart,
  input  wire logic [pspb_pkg::ADDR_BITS-1:0]   start_addr,
  pspb_in_if.sink                               src,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output pspb_pkg::entry_t                      q_data
);
  import pspb_pkg::*;

  logic [10:0]          pixel_column, pixel_column_next;
  logic [10:0]          byte_in_row, byte_in_row_next;
  logic [ADDR_BITS-1:0] row_address, row_address_next;

  logic        accept;
  logic [3:0]  count;
  logic [10:0] width_eff;
  logic [10:0] row_len;
  logic [10:0] bir_inc;
  logic [11:0] col_sum;
  logic [11:0] slot_col;
  logic [7:0]  idx;
  logic [7:0]  mask;
  logic        keyed;

  assign src.ready = !q_full;
  assign accept    = src.valid && src.ready;

  always_comb begin
    count     = slot_count(cfg.mode);
    width_eff = (cfg.width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : cfg.width;
    keyed     = !cfg.key[8];
    for (int s = 0; s < 8; s++) begin
      idx      = slot_index(src.source_byte, cfg.mode, 3'(s));
      slot_col = {1'b0, pixel_column} + 12'(s);
      mask[s]  = (4'(s) < count) && (slot_col < {1'b0, width_eff}) &&
                 !(keyed && (idx == cfg.key[7:0]));
    end
  end

  assign q_push          = accept && (mask != 8'd0);
  assign q_data.src_byte = src.source_byte;
  assign q_data.mask     = mask;
  assign q_data.base     = row_address + {{(ADDR_BITS-11){1'b0}}, pixel_column};

  always_comb begin
    col_sum  = {1'b0, pixel_column} + {8'd0, count};
    bir_inc  = byte_in_row + 11'd1;
    row_len  = (cfg.row_bytes == 11'd0) ? 11'd1 : cfg.row_bytes;
    pixel_column_next = pixel_column;
    byte_in_row_next  = byte_in_row;
    row_address_next  = row_address;
    if (restart) begin
      // start address is taken from the write itself
      pixel_column_next = '0;
      byte_in_row_next  = '0;
      row_address_next  = start_addr;
    end else if (accept) begin
      if (src.last_of_sprite) begin
        pixel_column_next = '0;
        byte_in_row_next  = '0;
        row_address_next  = cfg.dest_start;
      end else if (bir_inc >= row_len) begin
        pixel_column_next = '0;
        byte_in_row_next  = '0;
        row_address_next  = row_address + {{(ADDR_BITS-13){1'b0}}, cfg.pitch};
      end else begin
        // column saturates at its top code
        pixel_column_next = col_sum[11] ? 11'h7FF : col_sum[10:0];
        byte_in_row_next  = bir_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column <= '0;
      byte_in_row  <= '0;
      row_address  <= '0;
    end else begin
      pixel_column <= pixel_column_next;
      byte_in_row  <= byte_in_row_next;
      row_address  <= row_address_next;
    end
  end

  `PSPB_ASSERT_NEXT(a_restart_home, restart,
                    pixel_column == 11'd0 && byte_in_row == 11'd0)
  `PSPB_ASSERT_NEXT(a_last_home, accept && src.last_of_sprite,
                    pixel_column == 11'd0 && byte_in_row == 11'd0)
  `PSPB_ASSERT_NOW(a_push_ok, q_push, !q_full)

endmodule

`default_nettype wire

// File: design/pspb_queue.sv
// ---------------------------------------------------------------------------
// pspb_queue
// Short FIFO of pending source words between front and back.
// ---------------------------------------------------------------------------
`default_nettype none
`include "packed_sprite_palette_blitter_unit_macros.svh"

module pspb_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire pspb_pkg::entry_t  wdata,
  output logic                   full,
  input  wire logic              pop,
  output pspb_pkg::entry_t       rdata,
  output logic                   empty
);
  import pspb_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      fill <= fill + QCNT_W'(1);
      else if (pop && !push) fill <= fill - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  `PSPB_ASSERT_NOW(a_fill_bound, 1'b1, fill <= QCNT_W'(QUEUE_DEPTH))
  `PSPB_ASSERT_NOW(a_no_underflow, pop, !empty)
  `PSPB_ASSERT_NOW(a_no_overflow, push, !full)

endmodule

`default_nettype wire

// File: design/pspb_back.sv
// ---------------------------------------------------------------------------
// pspb_back
// Walks a word's write mask, one framebuffer write per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none
`include "packed_sprite_palette_blitter_unit_macros.svh"

module pspb_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pspb_pkg::cfg_t    cfg,
  input  wire pspb_pkg::entry_t  q_data,
  input  wire logic              q_empty,
  output logic                   q_pop,
  pspb_out_if.source             dst
);
  import pspb_pkg::*;

  logic   act_valid;
  entry_t act;
  logic   out_valid;

  logic [7:0]  onehot;
  logic [7:0]  mask_rest;
  logic [2:0]  slot;
  logic [7:0]  idx;
  logic [7:0]  color;
  logic        emit;
  logic        fin;

  always_comb begin
    onehot    = act.mask & (~act.mask + 8'd1);
    mask_rest = act.mask & ~onehot;
    slot      = 3'd0;
    for (int s = 0; s < 8; s++) begin
      if (onehot[s]) slot = 3'(s);
    end
    idx   = slot_index(act.src_byte, cfg.mode, slot);
    color = (cfg.mode == MODE_8BPP) ? act.src_byte : cfg.palette[{idx[3:0], 3'b000} +: 8];
  end

  assign emit  = act_valid && (!out_valid || dst.ready);
  assign fin   = emit && (mask_rest == 8'd0);
  assign q_pop = !q_empty && (!act_valid || fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop)    act_valid <= 1'b1;
      else if (fin) act_valid <= 1'b0;
      if (emit)           out_valid <= 1'b1;
      else if (dst.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop)     act      <= q_data;
    else if (emit) act.mask <= mask_rest;
    if (emit) begin
      dst.write_address <= act.base + {{(ADDR_BITS-3){1'b0}}, slot};
      dst.pixel_color   <= color;
      dst.last_in_run   <= (mask_rest == 8'd0);
    end
  end

  assign dst.valid = out_valid;

  `PSPB_ASSERT_NOW(a_act_has_work, act_valid, act.mask != 8'd0)
  `PSPB_ASSERT_NEXT(a_emit_shows, emit, out_valid)
  `PSPB_ASSERT_NOW(a_one_slot, emit, $onehot(onehot))

endmodule

`default_nettype wire

// File: design/packed_sprite_palette_blitter_unit.sv
// Path: source word -> queue -> back active word -> registered write word.
// Throughput: one write word per cycle while dst is ready, set by the single
//   back-stage write port; one write word per written pixel (up to 8 at 1bpp).
// Words with nothing to write are never queued and take no back-stage time.
// Reset (rst, synchronous, high): registers to defaults, queue emptied,
//   position back at the sprite start.
// ---------------------------------------------------------------------------
// packed_sprite_palette_blitter_unit
// Colour-keyed 1/2/4bpp-palette/8bpp-direct sprite blitter, APB register port.
// ---------------------------------------------------------------------------
`default_nettype none

module packed_sprite_palette_blitter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  pspb_in_if.sink          src,
  pspb_out_if.source       dst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import pspb_pkg::*;

  // registers, 64-bit slots at 8*i
  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     wr_en;
  logic     restart;

  entry_t   q_wdata;
  entry_t   q_rdata;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[5:3]);
  assign wr_en   = psel && penable && pwrite && pready;
  // a new start address opens a new sprite
  assign restart = wr_en && (reg_sel == REG_START);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_8BPP;
      cfg.width      <= 11'd1;
      cfg.row_bytes  <= 11'd1;
      cfg.dest_start <= '0;
      cfg.pitch      <= 13'd1;
      cfg.key        <= 9'h1FF;
      cfg.palette    <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MODE:      cfg.mode           <= pix_mode_t'(pwdata[1:0]);
        REG_WIDTH:     cfg.width          <= pwdata[10:0];
        REG_ROW_BYTES: cfg.row_bytes      <= pwdata[10:0];
        REG_START:     cfg.dest_start     <= pwdata[ADDR_BITS-1:0];
        REG_PITCH:     cfg.pitch          <= pwdata[12:0];
        REG_KEY:       cfg.key            <= pwdata[8:0];
        REG_PAL_LO:    cfg.palette[63:0]  <= pwdata;
        REG_PAL_HI:    cfg.palette[127:64] <= pwdata;
        default:       ;
      endcase
    end
  end

  // read-back of the addressed register
  always_comb begin
    unique case (reg_sel)
      REG_MODE:      prdata = {62'd0, cfg.mode};
      REG_WIDTH:     prdata = {53'd0, cfg.width};
      REG_ROW_BYTES: prdata = {53'd0, cfg.row_bytes};
      REG_START:     prdata = {{(64-ADDR_BITS){1'b0}}, cfg.dest_start};
      REG_PITCH:     prdata = {51'd0, cfg.pitch};
      REG_KEY:       prdata = {55'd0, cfg.key};
      REG_PAL_LO:    prdata = cfg.palette[63:0];
      REG_PAL_HI:    prdata = cfg.palette[127:64];
      default:       prdata = '0;
    endcase
  end

  // front: position tracking and write masks
  pspb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .restart    (restart),
    .start_addr (pwdata[ADDR_BITS-1:0]),
    .src        (src),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  // decoupling queue
  pspb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: palette lookup and one write word per cycle while dst is ready
  pspb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_data  (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .dst     (dst)
  );

endmodule

`default_nettype wire
